/* rtl/lrup_pkg.sv */
package lrup_pkg;

    localparam int FRAME_W = 8;

    // Frame numbers reachable through the frame field
    localparam int FRAME_SPAN = 2 ** FRAME_W;

    typedef enum logic {
        ACT_REFERENCE = 1'b0,
        ACT_EVICT     = 1'b1
    } t_action;

    typedef struct packed {
        t_action              action;
        logic [FRAME_W-1:0]   frame;
    } t_in_item;

    typedef struct packed {
        logic [FRAME_W-1:0]   victim_frame;
        logic                 victim_valid;
    } t_out_item;

endpackage

/* rtl/lrup_link_store.sv */
module lrup_link_store
    import lrup_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int FW    = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we0,
    input  logic [FW-1:0] i_wa0,
    input  logic [FW-1:0] i_wd0,
    input  logic          i_we1,
    input  logic [FW-1:0] i_wa1,
    input  logic [FW-1:0] i_wd1,
    input  logic          i_re,
    input  logic [FW-1:0] i_ra,
    output logic [FW-1:0] o_rd
);

    // Two banks, one per write port; the live value table picks the newer one
    logic [FW-1:0] r_bank_a [DEPTH];
    logic [FW-1:0] r_bank_b [DEPTH];
    logic          r_lvt    [DEPTH];

    logic [FW-1:0] r_rd_a;
    logic [FW-1:0] r_rd_b;
    logic          r_lvt_rd;
    logic [FW-1:0] r_ra;

    // Writes landing on the same edge as the read, not seen by the banks
    logic          r_byp0_en;
    logic [FW-1:0] r_byp0_addr;
    logic [FW-1:0] r_byp0_data;
    logic          r_byp1_en;
    logic [FW-1:0] r_byp1_addr;
    logic [FW-1:0] r_byp1_data;

    always_ff @(posedge i_clk) begin
        if (i_we0) begin
            r_bank_a[i_wa0] <= i_wd0;
        end
        if (i_re) begin
            r_rd_a <= r_bank_a[i_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we1) begin
            r_bank_b[i_wa1] <= i_wd1;
        end
        if (i_re) begin
            r_rd_b <= r_bank_b[i_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we0) begin
            r_lvt[i_wa0] <= 1'b0;
        end
        if (i_we1) begin
            r_lvt[i_wa1] <= 1'b1;
        end
        if (i_re) begin
            r_lvt_rd <= r_lvt[i_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_ra        <= i_ra;
            r_byp0_addr <= i_wa0;
            r_byp0_data <= i_wd0;
            r_byp1_addr <= i_wa1;
            r_byp1_data <= i_wd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp0_en <= 1'b0;
            r_byp1_en <= 1'b0;
        end else if (i_re) begin
            r_byp0_en <= i_we0;
            r_byp1_en <= i_we1;
        end
    end

    always_comb begin
        if (r_byp1_en && (r_byp1_addr == r_ra)) begin
            o_rd = r_byp1_data;
        end else if (r_byp0_en && (r_byp0_addr == r_ra)) begin
            o_rd = r_byp0_data;
        end else if (r_lvt_rd) begin
            o_rd = r_rd_b;
        end else begin
            o_rd = r_rd_a;
        end
    end

endmodule

/* rtl/lrup_list.sv */
module lrup_list
    import lrup_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int FW    = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_commit,
    input  t_action       i_action,
    input  logic          i_frame_ok,
    input  logic [FW-1:0] i_frame,
    input  logic [FW-1:0] i_prev_rd,
    input  logic [FW-1:0] i_next_rd,
    output logic [FW-1:0] o_tail_next,
    output logic [FW-1:0] o_victim,
    output logic          o_victim_valid,
    output logic          o_prev_we0,
    output logic [FW-1:0] o_prev_wa0,
    output logic [FW-1:0] o_prev_wd0,
    output logic          o_prev_we1,
    output logic [FW-1:0] o_prev_wa1,
    output logic [FW-1:0] o_prev_wd1,
    output logic          o_next_we0,
    output logic [FW-1:0] o_next_wa0,
    output logic [FW-1:0] o_next_wd0,
    output logic          o_next_we1,
    output logic [FW-1:0] o_next_wa1,
    output logic [FW-1:0] o_next_wd1
);

    logic             r_empty;
    logic [FW-1:0]    r_head;
    logic [FW-1:0]    r_tail;
    logic [DEPTH-1:0] r_linked;

    logic             n_empty;
    logic [FW-1:0]    n_head;
    logic [FW-1:0]    n_tail;
    logic             set_en;
    logic             clr_en;

    // Head's prev and tail's next are implied by position and never stored
    always_comb begin
        n_empty        = r_empty;
        n_head         = r_head;
        n_tail         = r_tail;
        set_en         = 1'b0;
        clr_en         = 1'b0;
        o_victim       = '0;
        o_victim_valid = 1'b0;
        o_prev_we0     = 1'b0;
        o_prev_wa0     = i_next_rd;
        o_prev_wd0     = i_prev_rd;
        o_prev_we1     = 1'b0;
        o_prev_wa1     = r_head;
        o_prev_wd1     = i_frame;
        o_next_we0     = 1'b0;
        o_next_wa0     = i_prev_rd;
        o_next_wd0     = i_next_rd;
        o_next_we1     = 1'b0;
        o_next_wa1     = i_frame;
        o_next_wd1     = r_head;
        if (i_action == ACT_EVICT) begin
            if (!r_empty) begin
                o_victim       = r_tail;
                o_victim_valid = 1'b1;
                clr_en         = 1'b1;
                if (r_head == r_tail) begin
                    n_empty = 1'b1;
                end else begin
                    n_tail = i_prev_rd;
                end
            end
        end else if (i_frame_ok) begin
            if (r_empty) begin
                n_empty = 1'b0;
                n_head  = i_frame;
                n_tail  = i_frame;
                set_en  = 1'b1;
            end else if (r_head != i_frame) begin
                // unlink from the middle or the tail first
                if (r_linked[i_frame]) begin
                    if (r_tail == i_frame) begin
                        n_tail = i_prev_rd;
                    end else begin
                        o_next_we0 = 1'b1;
                        o_prev_we0 = 1'b1;
                    end
                end
                o_next_we1 = 1'b1;
                o_prev_we1 = 1'b1;
                n_head     = i_frame;
                set_en     = 1'b1;
            end
        end
        if (!i_commit) begin
            o_prev_we0 = 1'b0;
            o_prev_we1 = 1'b0;
            o_next_we0 = 1'b0;
            o_next_we1 = 1'b0;
        end
    end

    assign o_tail_next = i_commit ? n_tail : r_tail;

    always_ff @(posedge i_clk) begin
        if (i_commit) begin
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty  <= 1'b1;
            r_linked <= '0;
        end else if (i_commit) begin
            r_empty <= n_empty;
            if (set_en) begin
                r_linked[i_frame] <= 1'b1;
            end
            if (clr_en) begin
                r_linked[r_tail] <= 1'b0;
            end
        end
    end

endmodule

/* rtl/lru_page_replacement.sv */
// Exact LRU order over the physical frames as a doubly linked recency list.
// An accepted item is registered in the input stage, then in the output register.
// Throughput: one item per cycle; the input stage advances whenever the output
// register is empty or being drained, so only output backpressure stalls it.
// Reset: the list is empty and all linked flags clear; link RAMs are not swept,
// a frame's links are used only while its linked flag is set.
module lru_page_replacement
    import lrup_pkg::*;
#(
    parameter int NUM_FRAMES = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    // Frames above what the frame field can name are never linked: no storage for them
    localparam int DEPTH = (NUM_FRAMES < FRAME_SPAN) ? NUM_FRAMES : FRAME_SPAN;
    localparam int FW    = $clog2(DEPTH);

    // Input stage: the accepted item, with the link reads landing alongside it
    logic       r_s1_valid;
    t_in_item   r_s1_item;

    // Result stage
    logic       r_out_valid;
    t_out_item  r_out_item;
    t_out_item  n_out_item;

    logic          accept;
    logic          commit;
    logic          frame_ok;
    logic [FW-1:0] s1_frame;
    logic [FW-1:0] tail_next;
    logic [FW-1:0] prev_ra;
    logic [FW-1:0] prev_rd;
    logic [FW-1:0] next_rd;
    logic [FW-1:0] victim;
    logic          victim_valid;

    logic          prev_we0;
    logic [FW-1:0] prev_wa0;
    logic [FW-1:0] prev_wd0;
    logic          prev_we1;
    logic [FW-1:0] prev_wa1;
    logic [FW-1:0] prev_wd1;
    logic          next_we0;
    logic [FW-1:0] next_wa0;
    logic [FW-1:0] next_wd0;
    logic          next_we1;
    logic [FW-1:0] next_wa1;
    logic [FW-1:0] next_wd1;

    // Advance the input stage when the result register frees up this cycle
    assign commit     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || commit;
    assign accept     = i_in_valid && o_in_ready;

    assign s1_frame = r_s1_item.frame[FW-1:0];
    assign frame_ok = {1'b0, r_s1_item.frame} < (FRAME_W + 1)'(DEPTH);

    // An evict needs the prev link of the tail as it stands after the item in flight
    assign prev_ra = (i_in_item.action == ACT_EVICT) ? tail_next : i_in_item.frame[FW-1:0];

    lrup_link_store #(
        .DEPTH (DEPTH),
        .FW    (FW)
    ) u_prev (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we0   (prev_we0),
        .i_wa0   (prev_wa0),
        .i_wd0   (prev_wd0),
        .i_we1   (prev_we1),
        .i_wa1   (prev_wa1),
        .i_wd1   (prev_wd1),
        .i_re    (accept),
        .i_ra    (prev_ra),
        .o_rd    (prev_rd)
    );

    lrup_link_store #(
        .DEPTH (DEPTH),
        .FW    (FW)
    ) u_next (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we0   (next_we0),
        .i_wa0   (next_wa0),
        .i_wd0   (next_wd0),
        .i_we1   (next_we1),
        .i_wa1   (next_wa1),
        .i_wd1   (next_wd1),
        .i_re    (accept),
        .i_ra    (i_in_item.frame[FW-1:0]),
        .o_rd    (next_rd)
    );

    lrup_list #(
        .DEPTH (DEPTH),
        .FW    (FW)
    ) u_list (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_commit       (commit),
        .i_action       (r_s1_item.action),
        .i_frame_ok     (frame_ok),
        .i_frame        (s1_frame),
        .i_prev_rd      (prev_rd),
        .i_next_rd      (next_rd),
        .o_tail_next    (tail_next),
        .o_victim       (victim),
        .o_victim_valid (victim_valid),
        .o_prev_we0     (prev_we0),
        .o_prev_wa0     (prev_wa0),
        .o_prev_wd0     (prev_wd0),
        .o_prev_we1     (prev_we1),
        .o_prev_wa1     (prev_wa1),
        .o_prev_wd1     (prev_wd1),
        .o_next_we0     (next_we0),
        .o_next_wa0     (next_wa0),
        .o_next_wd0     (next_wd0),
        .o_next_we1     (next_we1),
        .o_next_wa1     (next_wa1),
        .o_next_wd1     (next_wd1)
    );

    // Victim is zero unless an evict found a frame
    always_comb begin
        n_out_item.victim_frame = FRAME_W'(victim);
        n_out_item.victim_valid = victim_valid;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item <= i_in_item;
        end
        if (commit) begin
            r_out_item <= n_out_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (commit) begin
                r_s1_valid <= 1'b0;
            end
            // hold the result until taken; a fresh one replaces it on the same edge
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

/* tb/sv/tb_lru_page_replacement.sv */
`timescale 1ns / 100ps

module tb_lru_page_replacement;
    import lrup_pkg::*;

    localparam int N_FRAMES = 256;
    localparam int LINK_W = $clog2(N_FRAMES + 1);
    localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(N_FRAMES);
    localparam int POOL_SIZE = 12;
    localparam int IDLE_PCT = 14;

    typedef logic [LINK_W-1:0] t_link;

    // One scripted item; a pinned row carries its result written out by hand
    typedef struct {
        t_in_item  item;
        bit        pinned;
        t_out_item pinned_result;
    } t_script_row;

    localparam t_out_item NO_VICTIM = '{victim_frame: '0, victim_valid: 1'b0};

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item = '{action: ACT_REFERENCE, frame: '0};
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    // Recency list mirror: link toward the head and toward the tail
    t_link toward_head [N_FRAMES];
    t_link toward_tail [N_FRAMES];
    t_link mru_frame;
    t_link lru_frame;

    t_out_item victim_q [$];
    int        mismatch_cnt = 0;
    bit        in_idle_on = 1'b1;
    bit        out_idle_on = 1'b1;

    // Walk the directed table first: empty list, head, tail and middle
    // references, single-entry eviction, and every frame bit both ways.
    t_script_row script [20] = '{
        '{'{ACT_EVICT,     8'h00}, 1'b1, NO_VICTIM},
        '{'{ACT_REFERENCE, 8'h00}, 1'b1, NO_VICTIM},
        '{'{ACT_REFERENCE, 8'hFF}, 1'b1, NO_VICTIM},
        '{'{ACT_REFERENCE, 8'h00}, 1'b1, NO_VICTIM},
        '{'{ACT_REFERENCE, 8'h00}, 1'b1, NO_VICTIM},
        '{'{ACT_REFERENCE, 8'hAA}, 1'b1, NO_VICTIM},
        '{'{ACT_REFERENCE, 8'h00}, 1'b1, NO_VICTIM},
        '{'{ACT_REFERENCE, 8'h55}, 1'b1, NO_VICTIM},
        '{'{ACT_EVICT,     8'hFF}, 1'b0, NO_VICTIM},
        '{'{ACT_REFERENCE, 8'hAA}, 1'b1, NO_VICTIM},
        '{'{ACT_EVICT,     8'h55}, 1'b0, NO_VICTIM},
        '{'{ACT_EVICT,     8'h00}, 1'b0, NO_VICTIM},
        '{'{ACT_EVICT,     8'hAA}, 1'b0, NO_VICTIM},
        '{'{ACT_EVICT,     8'hFF}, 1'b1, NO_VICTIM},
        '{'{ACT_REFERENCE, 8'h7F}, 1'b1, NO_VICTIM},
        '{'{ACT_EVICT,     8'h80}, 1'b0, NO_VICTIM},
        '{'{ACT_REFERENCE, 8'h01}, 1'b1, NO_VICTIM},
        '{'{ACT_REFERENCE, 8'h02}, 1'b1, NO_VICTIM},
        '{'{ACT_REFERENCE, 8'h01}, 1'b1, NO_VICTIM},
        '{'{ACT_EVICT,     8'h00}, 1'b0, NO_VICTIM}
    };

    lru_page_replacement #(
        .NUM_FRAMES (N_FRAMES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void lru_clear();
        for (int i = 0; i < N_FRAMES; i++) begin
            toward_head[i] = NO_LINK;
            toward_tail[i] = NO_LINK;
        end
        mru_frame = NO_LINK;
        lru_frame = NO_LINK;
    endfunction

    // Move a frame to the head of the list, linking it in if absent
    function automatic void lru_touch(int f);
        t_link up;
        t_link down;
        if (f >= N_FRAMES) return;
        if (mru_frame == NO_LINK) begin
            mru_frame = t_link'(f);
            lru_frame = t_link'(f);
            toward_head[f] = NO_LINK;
            toward_tail[f] = NO_LINK;
            return;
        end
        if (mru_frame == t_link'(f)) return;
        up = toward_head[f];
        down = toward_tail[f];
        if (up != NO_LINK) begin
            // Unlink from the middle or the tail
            toward_tail[up] = down;
            if (lru_frame == t_link'(f))
                lru_frame = up;
            else if (down != NO_LINK)
                toward_head[down] = up;
        end
        toward_head[f] = NO_LINK;
        toward_tail[f] = mru_frame;
        toward_head[mru_frame] = t_link'(f);
        mru_frame = t_link'(f);
    endfunction

    // Apply one accepted item to the mirror and return the victim it yields
    function automatic t_out_item lru_step(t_in_item it);
        t_out_item res;
        t_link     victim;
        t_link     up;
        res = NO_VICTIM;
        if (it.action == ACT_REFERENCE) begin
            lru_touch(int'(it.frame));
        end else if (lru_frame != NO_LINK) begin
            victim = lru_frame;
            if (mru_frame == victim) begin
                mru_frame = NO_LINK;
                lru_frame = NO_LINK;
            end else begin
                up = toward_head[victim];
                if (up != NO_LINK) toward_tail[up] = NO_LINK;
                lru_frame = up;
            end
            toward_head[victim] = NO_LINK;
            toward_tail[victim] = NO_LINK;
            res.victim_frame = victim[FRAME_W-1:0];
            res.victim_valid = 1'b1;
        end
        return res;
    endfunction

    // Present one item, hold it until accepted, then queue its result
    task automatic send_item(input t_in_item it, input bit pinned, input t_out_item pin_res);
        t_out_item predicted;
        while (in_idle_on && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = lru_step(it);
        victim_q.push_back(pinned ? pin_res : predicted);
    endtask

    task automatic send_random(input int refer_pct, input logic [FRAME_W-1:0] frame);
        t_in_item it;
        it.frame = frame;
        if ($urandom_range(99) < refer_pct)
            it.action = ACT_REFERENCE;
        else
            it.action = ACT_EVICT;
        send_item(it, 1'b0, NO_VICTIM);
    endtask

    // Throttle the result side; drop the throttle during the back-to-back fill
    always @(posedge i_clk) begin
        if (out_idle_on)
            i_out_ready <= ($urandom_range(99) >= IDLE_PCT);
        else
            i_out_ready <= 1'b1;
    end

    // Compare each accepted result against the oldest pending one
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (victim_q.size() == 0) begin
                $error("result with nothing pending: victim_frame %0d victim_valid %0d",
                       o_out_item.victim_frame, o_out_item.victim_valid);
                mismatch_cnt++;
            end else begin
                want = victim_q.pop_front();
                if (o_out_item.victim_frame !== want.victim_frame) begin
                    $error("victim_frame: expected %0d, got %0d",
                           want.victim_frame, o_out_item.victim_frame);
                    mismatch_cnt++;
                end
                if (o_out_item.victim_valid !== want.victim_valid) begin
                    $error("victim_valid: expected %0d, got %0d",
                           want.victim_valid, o_out_item.victim_valid);
                    mismatch_cnt++;
                end
            end
        end
    end

    initial begin
        logic [FRAME_W-1:0] pool [POOL_SIZE];
        logic [FRAME_W-1:0] order [N_FRAMES];
        logic [FRAME_W-1:0] swap;
        int                 j;

        lru_clear();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[k])
            send_item(script[k].item, script[k].pinned, script[k].pinned_result);

        // Hit a small pool hard so references land on head, middle and tail
        for (int k = 0; k < 500; k++) begin
            if (k % 100 == 0)
                foreach (pool[p]) pool[p] = FRAME_W'($urandom_range(N_FRAMES - 1));
            send_random(70, pool[$urandom_range(POOL_SIZE - 1)]);
        end

        // Fill every frame in shuffled order, back to back on both sides
        in_idle_on = 1'b0;
        out_idle_on = 1'b0;
        foreach (order[k]) order[k] = FRAME_W'(k);
        for (int k = N_FRAMES - 1; k > 0; k--) begin
            j = $urandom_range(k);
            swap = order[k];
            order[k] = order[j];
            order[j] = swap;
        end
        foreach (order[k])
            send_item('{action: ACT_REFERENCE, frame: order[k]}, 1'b0, NO_VICTIM);
        in_idle_on = 1'b1;
        out_idle_on = 1'b1;

        // Churn over the full frame range, then drain past empty
        for (int k = 0; k < 300; k++)
            send_random(80, FRAME_W'($urandom_range(N_FRAMES - 1)));
        for (int k = 0; k < N_FRAMES + 4; k++)
            send_random(0, FRAME_W'($urandom_range(N_FRAMES - 1)));

        i_in_valid <= 1'b0;
        while (victim_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Stop a hung run
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
